// ----- hdl/ttc_pkg.sv -----
// Package for the thermocouple table conversion block.
// Holds the status codes, operation codes and register indexes. No dependencies.
package ttc_pkg;
    localparam logic       OP_LOAD    = 1'b0;
    localparam logic       OP_CONVERT = 1'b1;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNSORT  = 2'd1;
    localparam logic [1:0] ST_BELOW   = 2'd2;
    localparam logic [1:0] ST_ABOVE   = 2'd3;
    localparam logic [1:0] REG_ENTRIES = 2'd0;
    localparam logic [1:0] REG_TSORTED = 2'd1;
    localparam logic [1:0] REG_VSORTED = 2'd2;
    localparam int TEMP_W = 16;
    localparam int VOLT_W = 18;
    localparam int CFG_W  = 10;
endpackage

// ----- hdl/ttc_in_if.sv -----
// Input channel interface of the conversion block.
// Depends on ttc_pkg for field widths.
interface ttc_in_if;
    import ttc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [8:0]               entry_index;
    logic signed [TEMP_W-1:0] entry_temp;
    logic signed [VOLT_W-1:0] entry_microvolts;
    logic signed [VOLT_W-1:0] measured_microvolts;
    logic signed [TEMP_W-1:0] junction_temp;
    logic                     interp_enable;
    modport source (output valid, op, entry_index, entry_temp, entry_microvolts,
                    measured_microvolts, junction_temp, interp_enable, input ready);
    modport sink (input valid, op, entry_index, entry_temp, entry_microvolts,
                  measured_microvolts, junction_temp, interp_enable, output ready);
endinterface

// ----- hdl/ttc_out_if.sv -----
// Result channel interface of the conversion block.
// Depends on ttc_pkg for field widths.
interface ttc_out_if;
    import ttc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;
    logic [1:0]               status;
    modport source (output valid, temperature, status, input ready);
    modport sink (input valid, temperature, status, output ready);
endinterface

// ----- hdl/ttc_div.sv -----
// Restoring divider for the interpolation step, one quotient bit per cycle.
// Depends on nothing; signs are handled by the caller.
module ttc_div #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 19
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   n_shift;

    assign n_shift = {r_rem[DEN_W-1:0], r_quot[NUM_W-1]};

    // One shift and trial subtract each cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quot <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                if (n_shift >= {1'b0, r_den}) begin
                    r_rem  <= n_shift - {1'b0, r_den};
                    r_quot <= {r_quot[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem  <= n_shift;
                    r_quot <= {r_quot[NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ----- hdl/ttc_table.sv -----
// Table memory: temperature and voltage columns in one synchronous RAM.
// Depends on ttc_pkg for column widths.
module ttc_table #(
    parameter int DEPTH = 512
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [ttc_pkg::TEMP_W+ttc_pkg::VOLT_W-1:0] i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [ttc_pkg::TEMP_W+ttc_pkg::VOLT_W-1:0] o_rdata
);
    import ttc_pkg::*;
    logic [TEMP_W+VOLT_W-1:0] r_mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hdl/thermocouple_table_conversion.sv -----
// Top level of the thermocouple table conversion block.
// Depends on ttc_pkg, ttc_in_if, ttc_out_if, ttc_table and ttc_div.
//
//  channel   | direction | carries
//  ----------+-----------+-----------------------------------------------
//  i_in      | sink      | load entry or convert item
//  o_out     | source    | temperature and status, one per convert item
//  i_cfg_*   | write     | table_entries, temps_sorted, volts_sorted
//
// A load writes the table RAM at its accepting edge.
// A convert runs two searches over the one RAM read port. Each search reads and tests
// the end entries (S_RD0, S_RDN, S_RDLAST), makes up to ceil(log2(n-1)) probes, nine
// with 512 entries, each a probe read and compare (S_PROBE, S_PCMP), evaluates (S_EVAL),
// runs an interpolation division when needed (S_DIV) and closes the pass (S_FIN).
// After the second pass the output register is loaded in S_OUT; the input is ready
// again in the cycle after that load.
// A finished result waits while the output register still holds an unaccepted item.
// Reset is synchronous and active low; the table RAM is not cleared.
module thermocouple_table_conversion #(
    parameter int TABLE_DEPTH = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ttc_in_if.sink            i_in,
    ttc_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [ttc_pkg::CFG_W-1:0] i_cfg_data
);
    import ttc_pkg::*;

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int NW   = AW + 1;
    localparam int KW   = 20;      // keys and values after sign extension
    localparam int NUMW = 2 * KW - 4;
    localparam int DENW = KW - 1;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RDN, S_RDLAST, S_PROBE, S_PCMP, S_EVAL, S_DIV, S_FIN, S_OUT
    } t_state;

    t_state            r_state;
    logic [NW-1:0]     r_n;
    logic              r_tsort, r_vsort;
    logic              r_pass;      // 0 temperature search, 1 voltage search
    logic              r_interp;
    logic signed [KW-1:0] r_x;
    logic signed [VOLT_W-1:0] r_meas;
    logic [AW-1:0]     r_lo, r_hi, r_addr;
    logic signed [KW-1:0] r_klo, r_khi, r_dlo, r_dhi, r_res;
    logic [1:0]        r_c1, r_clamp;
    logic              r_neg;
    logic signed [KW-1:0] r_out_t;
    logic [1:0]        r_out_s;
    logic              r_out_v;

    logic [TEMP_W+VOLT_W-1:0] w_rdata;
    logic signed [KW-1:0] w_t, w_v, w_rkey, w_rval;
    logic              w_we;
    logic              div_start, div_done;
    logic [NUMW-1:0]   div_quot;
    logic [NUMW-1:0]   n_num;
    logic [DENW-1:0]   n_den;
    logic signed [KW:0]   n_dd, n_dx, n_dh, n_span;
    logic signed [2*KW+1:0] n_prod;
    logic signed [KW+1:0] n_r;
    logic signed [KW-1:0] n_mn, n_mx, n_rc, n_near;
    logic [NW-1:0]     n_ncfg;
    logic              w_le;
    logic [AW-1:0]     n_lo, n_hi, n_mid;
    logic              n_more;
    logic              w_out_load;
    logic              n_out_v;

    // Loads outside the table depth are dropped.
    assign w_we = i_in.valid && i_in.ready && (i_in.op == OP_LOAD)
                  && (32'(i_in.entry_index) < 32'(TABLE_DEPTH));

    ttc_table #(.DEPTH(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_in.entry_index)),
        .i_wdata ({i_in.entry_temp, i_in.entry_microvolts}),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // Key and value of the read entry for the current search pass.
    assign w_t    = KW'(signed'(w_rdata[TEMP_W+VOLT_W-1:VOLT_W]));
    assign w_v    = KW'(signed'(w_rdata[VOLT_W-1:0]));
    assign w_rkey = r_pass ? w_v : w_t;
    assign w_rval = r_pass ? w_t : w_v;

    // Bracket update for one probe.
    assign w_le   = (w_rkey <= r_x);
    assign n_lo   = w_le ? r_addr : r_lo;
    assign n_hi   = w_le ? r_hi : r_addr;
    assign n_mid  = AW'(({1'b0, n_lo} + {1'b0, n_hi}) >> 1);
    assign n_more = (n_hi - n_lo) > AW'(1);

    // Interpolation operands: |dd*dx| by span, sign applied afterwards.
    assign n_dd   = (KW+1)'(r_dhi) - (KW+1)'(r_dlo);
    assign n_dx   = (KW+1)'(r_x) - (KW+1)'(r_klo);
    assign n_dh   = (KW+1)'(r_khi) - (KW+1)'(r_x);
    assign n_span = (KW+1)'(r_khi) - (KW+1)'(r_klo);
    assign n_prod = (2*KW+2)'(n_dd) * (2*KW+2)'(n_dx);
    assign n_num  = NUMW'(n_prod < 0 ? -n_prod : n_prod);
    assign n_den  = DENW'(n_span);
    assign div_start = (r_state == S_EVAL) && r_interp && (r_x != r_klo)
                       && (r_x != r_khi) && (n_span > 0);

    ttc_div #(.NUM_W(NUMW), .DEN_W(DENW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (n_num),
        .i_den   (n_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Interpolated value clamped to the bracket, and the nearest entry.
    assign n_r  = (KW+2)'(r_dlo) + (r_neg ? -(KW+2)'(signed'({1'b0, div_quot}))
                                          : (KW+2)'(signed'({1'b0, div_quot})));
    assign n_mn = (r_dlo < r_dhi) ? r_dlo : r_dhi;
    assign n_mx = (r_dlo < r_dhi) ? r_dhi : r_dlo;
    assign n_rc = (n_r < (KW+2)'(n_mn)) ? n_mn
                : (n_r > (KW+2)'(n_mx)) ? n_mx : KW'(n_r);
    assign n_near = (n_dx < n_dh) ? r_dlo : r_dhi;

    assign n_ncfg = (i_cfg_data < CFG_W'(2)) ? NW'(2)
                  : (32'(i_cfg_data) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                  : NW'(i_cfg_data);

    // Output register: loaded when free or being emptied in the same cycle.
    assign w_out_load = (r_state == S_OUT) && (!r_out_v || o_out.ready);
    assign n_out_v    = w_out_load ? 1'b1 : (o_out.valid && o_out.ready) ? 1'b0 : r_out_v;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_v;
    assign o_out.temperature = TEMP_W'(r_out_t);
    assign o_out.status = r_out_s;

    // Search sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= NW'(2);
            r_tsort <= 1'b1;
            r_vsort <= 1'b1;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ENTRIES: r_n     <= n_ncfg;
                    REG_TSORTED: r_tsort <= i_cfg_data[0];
                    REG_VSORTED: r_vsort <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_out_v <= n_out_v;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready && i_in.op == OP_CONVERT) begin
                        r_interp <= i_in.interp_enable;
                        r_meas   <= i_in.measured_microvolts;
                        r_x      <= KW'(i_in.junction_temp);
                        r_pass   <= 1'b0;
                        r_c1     <= ST_OK;
                        if (!r_tsort || !r_vsort) begin
                            r_res   <= '0;
                            r_clamp <= ST_UNSORT;
                            r_state <= S_OUT;
                        end else begin
                            r_addr  <= '0;
                            r_state <= S_RD0;
                        end
                    end
                end
                S_RD0: begin
                    r_addr  <= AW'(r_n - 1'b1);
                    r_state <= S_RDN;
                end
                S_RDN: begin
                    r_klo   <= w_rkey;
                    r_dlo   <= w_rval;
                    r_state <= S_RDLAST;
                end
                S_RDLAST: begin
                    // Last entry present: test both ends, then start the search.
                    r_khi <= w_rkey;
                    r_dhi <= w_rval;
                    r_lo  <= '0;
                    r_hi  <= AW'(r_n - 1'b1);
                    if (r_x < r_klo) begin
                        r_clamp <= ST_BELOW;
                        r_res   <= r_dlo;
                        r_state <= S_FIN;
                    end else if (r_x > w_rkey) begin
                        r_clamp <= ST_ABOVE;
                        r_res   <= w_rval;
                        r_state <= S_FIN;
                    end else begin
                        r_clamp <= ST_OK;
                        if (r_n > NW'(2)) begin
                            r_addr  <= AW'((r_n - 1'b1) >> 1);
                            r_state <= S_PROBE;
                        end else begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_PROBE: begin
                    // Probe address set; wait state for the RAM read.
                    r_state <= S_PCMP;
                end
                S_PCMP: begin
                    if (w_le) begin
                        r_klo <= w_rkey;
                        r_dlo <= w_rval;
                    end else begin
                        r_khi <= w_rkey;
                        r_dhi <= w_rval;
                    end
                    r_lo <= n_lo;
                    r_hi <= n_hi;
                    if (n_more) begin
                        r_addr  <= n_mid;
                        r_state <= S_PROBE;
                    end else begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    // Exact matches first, then nearest entry, interpolation, or the low entry for a non-positive span.
                    priority if (r_x == r_klo) begin
                        r_res   <= r_dlo;
                        r_state <= S_FIN;
                    end else if (r_x == r_khi) begin
                        r_res   <= r_dhi;
                        r_state <= S_FIN;
                    end else if (!r_interp) begin
                        r_res   <= n_near;
                        r_state <= S_FIN;
                    end else if (n_span <= 0) begin
                        r_res   <= r_dlo;
                        r_state <= S_FIN;
                    end else begin
                        r_neg   <= (n_prod < 0);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_res   <= n_rc;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // The compensation voltage feeds the voltage search.
                    if (!r_pass) begin
                        r_c1    <= r_clamp;
                        r_x     <= KW'(r_meas) + r_res;
                        r_pass  <= 1'b1;
                        r_addr  <= '0;
                        r_state <= S_RD0;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_out_t <= r_res;
                        r_out_s <= (r_clamp != ST_OK) ? r_clamp : r_c1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
